// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Request codes, command encoding and the packed transfer types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Grid size defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Depth of the command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  // Character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ZERO_CODE    = 8'd0;

  // Request type codes on the input port
  localparam logic [2:0] REQ_PUT    = 3'd0;
  localparam logic [2:0] REQ_REWIND = 3'd1;
  localparam logic [2:0] REQ_SETCUR = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  typedef logic [6:0] col_t;
  typedef logic [4:0] row_t;
  typedef logic [7:0] char_t;

  typedef struct packed {
    logic [2:0] req_type;
    char_t      char_code;
    col_t       col;
    row_t       row;
  } in_item_t;

  typedef struct packed {
    col_t  cursor_col_now;
    row_t  cursor_row_now;
    char_t cell_char;
  } out_item_t;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_REWIND,
    OP_SETCUR,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e   op;
    char_t ch;
    col_t  col;      // clamped to the grid
    row_t  row;      // clamped to the grid
    logic  in_range; // raw col/row fall inside the grid
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front: request intake and decode
// Registers one request, decodes it into a command and clamps coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire tcw_pkg::in_item_t  in_data,
  output logic                    q_push,
  input  wire logic               q_full,
  output tcw_pkg::cmd_t           q_wdata
);

  logic          vld_r, vld_nxt;
  tcw_pkg::cmd_t cmd_r, cmd_nxt;
  logic          accept;

  assign full    = vld_r && q_full;
  assign accept  = push && !full;
  assign q_push  = vld_r && !q_full;
  assign q_wdata = cmd_r;

  always_comb begin
    cmd_nxt.ch       = in_data.char_code;
    cmd_nxt.col      = (int'(in_data.col) > COLUMNS - 1) ?
                       tcw_pkg::col_t'(COLUMNS - 1) : in_data.col;
    cmd_nxt.row      = (int'(in_data.row) > ROWS - 1) ?
                       tcw_pkg::row_t'(ROWS - 1) : in_data.row;
    cmd_nxt.in_range = (int'(in_data.col) < COLUMNS) && (int'(in_data.row) < ROWS);
    unique case (in_data.req_type)
      tcw_pkg::REQ_PUT:    cmd_nxt.op = (in_data.char_code == tcw_pkg::NEWLINE_CODE) ?
                                        tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
      tcw_pkg::REQ_REWIND: cmd_nxt.op = tcw_pkg::OP_REWIND;
      tcw_pkg::REQ_SETCUR: cmd_nxt.op = tcw_pkg::OP_SETCUR;
      tcw_pkg::REQ_CLEAR:  cmd_nxt.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::REQ_READ:   cmd_nxt.op = tcw_pkg::OP_READ;
      default:             cmd_nxt.op = tcw_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tcw_cmd_q.sv =====
// ----------------------------------------------------------------------------
// tcw_cmd_q: command queue
// Small register FIFO that decouples decode from execution.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cmd_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcw_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output tcw_pkg::cmd_t      rdata,
  output logic               empty
);

  localparam int DEPTH = tcw_pkg::CMDQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  tcw_pkg::cmd_t     ent_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back: command execution
// Cursor, row ring with per-row valid bits, cell store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire tcw_pkg::cmd_t  q_rdata,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output tcw_pkg::out_item_t  out_data
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * (2 ** CW);

  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);

  typedef logic [CW-1:0] ccol_t;
  typedef logic [RW-1:0] crow_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_FILL   = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e             state_r, state_nxt;
  tcw_pkg::cmd_t      cmd_r, cmd_nxt;
  ccol_t              col_r, col_nxt;
  crow_t              row_r, row_nxt;
  crow_t              top_r, top_nxt;
  logic [ROWS-1:0]    vld_r, vld_nxt;
  crow_t              fill_row_r, fill_row_nxt;
  ccol_t              fill_cnt_r, fill_cnt_nxt;
  tcw_pkg::char_t     fill_val_r, fill_val_nxt;
  logic               fill_back_r, fill_back_nxt;
  tcw_pkg::char_t     cell_r, cell_nxt;
  tcw_pkg::out_item_t out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;

  logic               we;
  logic [RW+CW-1:0]   waddr, raddr;
  tcw_pkg::char_t     wdata, rdata;
  crow_t              cur_phys, rd_phys;
  crow_t              rd_row;
  ccol_t              rd_col;

  // Logical row to physical row through the scroll offset
  function automatic crow_t phys_row(crow_t lrow, crow_t top);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= ROWS_W) begin
      sum = sum - ROWS_W;
    end
    return sum[RW-1:0];
  endfunction

  assign rd_row   = crow_t'(cmd_r.row);
  assign rd_col   = ccol_t'(cmd_r.col);
  assign cur_phys = phys_row(row_r, top_r);
  assign rd_phys  = phys_row(rd_row, top_r);
  assign raddr    = {rd_phys, rd_col};

  assign empty    = !out_vld_r;
  assign out_data = out_r;

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    top_nxt       = top_r;
    vld_nxt       = vld_r;
    fill_row_nxt  = fill_row_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_val_nxt  = fill_val_r;
    fill_back_nxt = fill_back_r;
    cell_nxt      = cell_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r && !pop;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = {fill_row_r, fill_cnt_r};
    wdata         = fill_val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_rdata;
          cell_nxt  = tcw_pkg::ZERO_CODE;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_RESP;
        unique case (cmd_r.op)
          tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
            if (cmd_r.op == tcw_pkg::OP_PUT && !vld_r[cur_phys]) begin
              // first touch of a cleared row: zero it, then come back
              fill_row_nxt       = cur_phys;
              fill_cnt_nxt       = '0;
              fill_val_nxt       = tcw_pkg::ZERO_CODE;
              fill_back_nxt      = 1'b1;
              vld_nxt[cur_phys]  = 1'b1;
              state_nxt          = ST_FILL;
            end else begin
              if (cmd_r.op == tcw_pkg::OP_PUT) begin
                we    = 1'b1;
                waddr = {cur_phys, col_r};
                wdata = cmd_r.ch;
              end
              if (cmd_r.op == tcw_pkg::OP_PUT && col_r != LAST_COL) begin
                col_nxt = col_r + 1'b1;
              end else begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  // scroll: old top row becomes the blank bottom row
                  top_nxt         = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
                  fill_row_nxt    = top_r;
                  fill_cnt_nxt    = '0;
                  fill_val_nxt    = tcw_pkg::SPACE_CODE;
                  fill_back_nxt   = 1'b0;
                  vld_nxt[top_r]  = 1'b1;
                  state_nxt       = ST_FILL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
          end
          tcw_pkg::OP_REWIND: begin
            if (col_r == '0) begin
              if (row_r != '0) begin
                row_nxt = row_r - 1'b1;
                col_nxt = LAST_COL;
              end
            end else begin
              col_nxt = col_r - 1'b1;
            end
          end
          tcw_pkg::OP_SETCUR: begin
            col_nxt = rd_col;
            row_nxt = rd_row;
          end
          tcw_pkg::OP_CLEAR: begin
            vld_nxt = '0;
            col_nxt = '0;
            row_nxt = '0;
            top_nxt = '0;
          end
          tcw_pkg::OP_READ: begin
            if (cmd_r.in_range && vld_r[rd_phys]) begin
              state_nxt = ST_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end

      ST_FILL: begin
        we = 1'b1;
        if (fill_cnt_r == LAST_COL) begin
          state_nxt = fill_back_r ? ST_EXEC : ST_RESP;
        end else begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end

      ST_RDWAIT: begin
        cell_nxt  = rdata;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_r || pop) begin
          out_nxt.cursor_col_now = tcw_pkg::col_t'(col_r);
          out_nxt.cursor_row_now = tcw_pkg::row_t'(row_r);
          out_nxt.cell_char      = cell_r;
          out_vld_nxt            = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      top_r     <= '0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      top_r     <= top_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    fill_row_r  <= fill_row_nxt;
    fill_cnt_r  <= fill_cnt_nxt;
    fill_val_r  <= fill_val_nxt;
    fill_back_r <= fill_back_nxt;
    cell_r      <= cell_nxt;
    out_r       <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: character-cell console with cursor and scroll
// An in-grid read of a row written or blanked since reset or clear also
// passes through a read-wait state for the registered cell store.
// The execution unit finishes each request before it takes the next;
// a line feed or wrap on the last row also blanks the new bottom row,
// and the first write to a row after reset or clear first zero-fills it.
// Reset: synchronous; cursor home, all rows read as zero, no sweep needed.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request queue side: transfer when push && !full
  input  wire logic               push,
  output logic                    full,
  input  wire tcw_pkg::in_item_t  in_data,
  // result queue side: transfer when pop && !empty
  output logic                    empty,
  input  wire logic               pop,
  output tcw_pkg::out_item_t      out_data
);

  // Structure:
  //   front  - one-entry intake register; decodes the request type, folds
  //            newline into its own command and clamps set-cursor coordinates
  //   queue  - short command FIFO so intake keeps taking transfers while the
  //            back end is busy blanking a row
  //   back   - sequencer that owns the cursor and the cell store
  //
  // Scrolling never moves data. The store is a ring of rows: a top-row
  // offset maps logical rows to physical rows, and a scroll just advances
  // the offset and rewrites the retired row with spaces, one cell a cycle.
  // Clear drops every per-row valid bit; a row with its bit down reads as
  // zero and is zero-filled before its first write. Cells sit at
  // {physical row, column}, so the store is ROWS * 2**clog2(COLUMNS) bytes.

  logic          q_push, q_full, q_pop, q_empty;
  tcw_pkg::cmd_t q_wdata, q_rdata;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_wdata (q_wdata)
  );

  tcw_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for text_console_writer
// Drives console requests through the push/full queue port and checks every
// result popped from the empty/pop port against a cycle-free mirror of the
// screen and cursor, kept in step as each request transfer is accepted.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int LINES = tcw_pkg::ROWS_DEF;
  localparam int CELLS = COLS * LINES;

  // request codes the block decodes as no-ops
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int MAX_SHOWN     = 10;
  localparam int DRAIN_LIMIT   = 50000;  // cycles allowed for the tail to empty
  localparam int SETTLE_CYCLES = 16;     // settle time for any extra result to show

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  tcw_pkg::in_item_t  in_data;
  logic               empty;
  logic               pop;
  tcw_pkg::out_item_t out_data;

  text_console_writer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Screen mirror: cell bytes plus cursor, updated per accepted request.
  // --------------------------------------------------------------------------
  tcw_pkg::char_t     screen_mirror [CELLS];
  int                 mirror_col;
  int                 mirror_row;
  tcw_pkg::out_item_t console_status_q [$];   // predicted results, oldest first

  int  mismatch_count;
  bit  idle_on;                      // random gaps on both sides
  int  hold_cycles_req;              // long receiver hold-off, picked up once

  // Line feed: step down a row, or scroll everything up one row and blank
  // the bottom row with spaces when already on the last row.
  function automatic void advance_line();
    if (mirror_row == LINES - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_mirror[i] = tcw_pkg::SPACE_CODE;
    end else begin
      mirror_row++;
    end
  endfunction

  function automatic tcw_pkg::out_item_t console_execute(tcw_pkg::in_item_t req);
    tcw_pkg::out_item_t res;
    res.cell_char = tcw_pkg::ZERO_CODE;
    case (req.req_type)
      tcw_pkg::REQ_PUT: begin
        if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
          // newline is never stored
          mirror_col = 0;
          advance_line();
        end else begin
          screen_mirror[mirror_row * COLS + mirror_col] = req.char_code;
          if (mirror_col == COLS - 1) begin
            mirror_col = 0;
            advance_line();
          end else begin
            mirror_col++;
          end
        end
      end
      tcw_pkg::REQ_REWIND: begin
        // at column 0 back up to the end of the previous row, never past home
        if (mirror_col != 0) begin
          mirror_col--;
        end else if (mirror_row != 0) begin
          mirror_row--;
          mirror_col = COLS - 1;
        end
      end
      tcw_pkg::REQ_SETCUR: begin
        mirror_col = (int'(req.col) > COLS - 1)  ? COLS - 1  : int'(req.col);
        mirror_row = (int'(req.row) > LINES - 1) ? LINES - 1 : int'(req.row);
      end
      tcw_pkg::REQ_CLEAR: begin
        // clear writes zero bytes, not spaces
        foreach (screen_mirror[i]) screen_mirror[i] = tcw_pkg::ZERO_CODE;
        mirror_col = 0;
        mirror_row = 0;
      end
      tcw_pkg::REQ_READ: begin
        if (int'(req.col) < COLS && int'(req.row) < LINES)
          res.cell_char = screen_mirror[int'(req.row) * COLS + int'(req.col)];
      end
      default: begin
      end
    endcase
    res.cursor_col_now = tcw_pkg::col_t'(mirror_col);
    res.cursor_row_now = tcw_pkg::row_t'(mirror_row);
    return res;
  endfunction

  function automatic tcw_pkg::in_item_t make_req(logic [2:0] kind, int ch, int c, int r);
    tcw_pkg::in_item_t it;
    it.req_type  = kind;
    it.char_code = tcw_pkg::char_t'(ch);
    it.col       = tcw_pkg::col_t'(c);
    it.row       = tcw_pkg::row_t'(r);
    return it;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("[%0t] ERROR %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Drive at the falling edge, accept at the rising edge when
  // full is low. push stays high across back-to-back transfers.
  // --------------------------------------------------------------------------
  task automatic send_request(tcw_pkg::in_item_t item);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full);
    console_status_q.push_back(console_execute(item));
  endtask

  // --------------------------------------------------------------------------
  // Result side: pop policy, one decision per falling edge. A requested
  // hold-off is counted out here in whole cycles.
  // --------------------------------------------------------------------------
  initial begin
    int n;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        pop <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        pop <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Result checker: every popped transfer against the oldest prediction.
  always @(posedge clk) begin
    tcw_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (console_status_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result col=%0d row=%0d cell=%0d",
                      out_data.cursor_col_now, out_data.cursor_row_now,
                      out_data.cell_char));
      end else begin
        want = console_status_q.pop_front();
        if (out_data.cursor_col_now !== want.cursor_col_now ||
            out_data.cursor_row_now !== want.cursor_row_now ||
            out_data.cell_char      !== want.cell_char)
          note_mismatch($sformatf(
            "result exp col=%0d row=%0d cell=%0d got col=%0d row=%0d cell=%0d",
            want.cursor_col_now, want.cursor_row_now, want.cell_char,
            out_data.cursor_col_now, out_data.cursor_row_now, out_data.cell_char));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random request mix. text_pct sets the share of put-char requests; the
  // rest split between cell reads and cursor/screen control. Fields a request
  // ignores still carry random bits.
  // --------------------------------------------------------------------------
  function automatic tcw_pkg::in_item_t random_request(int text_pct);
    tcw_pkg::in_item_t it;
    int pick;
    int sub;
    it = make_req(tcw_pkg::REQ_PUT, $urandom_range(0, 255), $urandom_range(0, 127),
                  $urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < text_pct) begin
      // about one line feed per sixteen characters
      if ($urandom_range(0, 15) == 0) it.char_code = tcw_pkg::NEWLINE_CODE;
    end else if (pick < text_pct + (100 - text_pct) / 2) begin
      it.req_type = tcw_pkg::REQ_READ;
      if ($urandom_range(0, 7) != 0) begin
        it.col = tcw_pkg::col_t'($urandom_range(0, COLS - 1));
        it.row = tcw_pkg::row_t'($urandom_range(0, LINES - 1));
      end
    end else begin
      sub = $urandom_range(0, 9);
      if (sub <= 3 || (sub == 7 && $urandom_range(0, 9) != 0)) begin
        it.req_type = tcw_pkg::REQ_REWIND;
      end else if (sub <= 6) begin
        it.req_type = tcw_pkg::REQ_SETCUR;
        if ($urandom_range(0, 3) != 0) begin
          it.col = tcw_pkg::col_t'($urandom_range(0, COLS - 1));
          it.row = tcw_pkg::row_t'($urandom_range(0, LINES - 1));
        end
      end else if (sub == 7) begin
        it.req_type = tcw_pkg::REQ_CLEAR;
      end else begin
        it.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      end
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fresh screen reads zero at both corners.
  task automatic test_reset_contents();
    send_request(make_req(tcw_pkg::REQ_READ, 8'hFF, 0, 0));
    send_request(make_req(tcw_pkg::REQ_READ, 8'h00, COLS - 1, LINES - 1));
  endtask

  // Extreme bytes at home, then a character in the very last cell: the wrap
  // must scroll and blank the bottom row with spaces.
  task automatic test_put_wrap_scroll();
    send_request(make_req(tcw_pkg::REQ_PUT, 8'hFF, 127, 31));
    send_request(make_req(tcw_pkg::REQ_PUT, 8'h00, 0, 0));
    send_request(make_req(tcw_pkg::REQ_SETCUR, 0, COLS - 1, LINES - 1));
    send_request(make_req(tcw_pkg::REQ_PUT, "A", 0, 0));
    send_request(make_req(tcw_pkg::REQ_READ, 0, COLS - 1, LINES - 2));
    send_request(make_req(tcw_pkg::REQ_READ, 0, 0, LINES - 1));
  endtask

  // Newline on the last row scrolls; newline mid-screen only moves down to column 0.
  task automatic test_newline();
    send_request(make_req(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 0, 0));
    send_request(make_req(tcw_pkg::REQ_READ, 0, COLS - 1, LINES - 3));
    send_request(make_req(tcw_pkg::REQ_SETCUR, 0, 5, 3));
    send_request(make_req(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE, 99, 17));
    send_request(make_req(tcw_pkg::REQ_READ, 0, 5, 3));
  endtask

  // Rewind: column 0 backs into the previous row, top-left stays put.
  task automatic test_rewind();
    send_request(make_req(tcw_pkg::REQ_SETCUR, 0, 0, LINES - 1));
    send_request(make_req(tcw_pkg::REQ_REWIND, 0, 0, 0));
    send_request(make_req(tcw_pkg::REQ_REWIND, 0, 0, 0));
    send_request(make_req(tcw_pkg::REQ_SETCUR, 0, 0, 0));
    send_request(make_req(tcw_pkg::REQ_REWIND, 8'hFF, 127, 31));
  endtask

  // Set cursor beyond the grid clamps each axis independently.
  task automatic test_set_cursor_clamp();
    send_request(make_req(tcw_pkg::REQ_SETCUR, 0, 127, 31));
    send_request(make_req(tcw_pkg::REQ_SETCUR, 0, COLS, 2));
  endtask

  // Read outside the grid returns zero and moves nothing.
  task automatic test_read_outside();
    send_request(make_req(tcw_pkg::REQ_READ, 0, COLS, 0));
    send_request(make_req(tcw_pkg::REQ_READ, 0, 127, 31));
    send_request(make_req(tcw_pkg::REQ_READ, 0, 0, LINES));
  endtask

  // Spare request codes leave everything as it was.
  task automatic test_spare_codes();
    for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
      send_request(make_req(3'(k), $urandom_range(0, 255), $urandom_range(0, 127),
                            $urandom_range(0, 31)));
  endtask

  // Clear homes the cursor and leaves zero bytes where spaces were.
  task automatic test_clear();
    send_request(make_req(tcw_pkg::REQ_CLEAR, 8'hFF, 127, 31));
    send_request(make_req(tcw_pkg::REQ_READ, 0, 0, LINES - 1));
    send_request(make_req(tcw_pkg::REQ_READ, 0, COLS - 1, LINES - 3));
  endtask

  // Receiver stalls for a long stretch while requests keep coming, so the
  // block backs up and raises full.
  task automatic test_backpressure();
    bit saved;
    saved = idle_on;
    idle_on = 1'b0;
    hold_cycles_req = 400;
    repeat (30) send_request(random_request(60));
    idle_on = saved;
  endtask

  // Mostly running text with lots of scrolling, sprinkled with reads.
  task automatic test_random_text(int count);
    repeat (count) send_request(random_request(70));
  endtask

  // Mixed run: put-char requests are a minority, the rest split between reads and control.
  task automatic test_random_mixed(int count);
    repeat (count) send_request(random_request(30));
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate(int count);
    idle_on = 1'b0;
    repeat (count) send_request(random_request(50));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_data         = '0;
    mismatch_count  = 0;
    idle_on         = 1'b1;
    hold_cycles_req = 0;
    mirror_col      = 0;
    mirror_row      = 0;
    foreach (screen_mirror[i]) screen_mirror[i] = tcw_pkg::ZERO_CODE;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_put_wrap_scroll();
    test_newline();
    test_rewind();
    test_set_cursor_clamp();
    test_read_outside();
    test_spare_codes();
    test_clear();
    test_backpressure();
    test_random_text(700);
    test_random_mixed(280);
    test_full_rate(120);

    @(negedge clk);
    push <= 1'b0;

    // let the tail drain, then give the block time to show anything extra
    waited = 0;
    while (console_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (console_status_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", console_status_q.size()));

    if (mismatch_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

  // Watchdog: ends the run as a mismatch if it never finishes.
  initial begin
    #20_000_000;
    $display("text_console_writer: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_cmd_q.sv
src/tcw_back.sv
src/text_console_writer.sv
verif/tb.sv
